[src/assert_macros.svh]
// assertion helpers for the normaliser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[src/zsn_pkg.sv]
package zsn_pkg;
   localparam int MAX_SAMPLES_DEF = 64;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int FIELD_BITS      = 16;
   localparam int Z_FRAC_BITS     = 11;

   // controller to datapath
   typedef struct packed {
      logic load;       // store an accepted sample
      logic drop;       // accepted sample arrived while full
      logic clear;      // clear accumulators for next set
      logic mean_start; // start mean division
      logic var_clr;    // clear sum of squares
      logic var_acc;    // accumulate square of read entry
      logic var_start;  // start variance division
      logic sqrt_start; // start square root
      logic z_start;    // start one output division
      logic rd_en;      // read sample store
      logic [6:0] rd_addr;
   } zsn_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_busy;
      logic sqrt_busy;
      logic full;
      logic [6:0] count;
   } zsn_stat_type;
endpackage

[src/zscore_normaliser_unit.sv]
// z-score normaliser
// requests: req_valid/req_stall with req_sample and req_last_in; one sample
// is taken per cycle while loading, the request with req_last_in closes the set
// responses: rsp_valid/rsp_stall with rsp_normalised (Q4.11), rsp_last_out,
// rsp_degenerate; one response per held sample in load order
// after the last request: mean division, a second pass over the buffer,
// variance division and a square root; then each response is computed by the
// shared bit-serial divider (59 steps at the default sizes), or without a
// division when the deviation is zero
// req_stall is high from the closing request until the cycle after the last
// response leaves, when the set is cleared
// a stalled response holds steady; the block waits for it
// reset clears counts, the sample sum and flags; the buffer needs no clearing
// samples beyond the buffer depth are dropped and raise rsp_degenerate
`include "assert_macros.svh"
module zscore_normaliser_unit #(
   parameter int MAX_SAMPLES = zsn_pkg::MAX_SAMPLES_DEF,
   parameter int SAMPLE_BITS = zsn_pkg::SAMPLE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_sample,
   input  logic               req_last_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_normalised,
   output logic               rsp_last_out,
   output logic               rsp_degenerate
);
   zsn_pkg::zsn_cmd_type  cmd;
   zsn_pkg::zsn_stat_type stat;

   // control sequencer
   zsn_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_last_in, .req_stall,
      .rsp_valid, .rsp_last_out, .rsp_stall, .cmd, .stat
   );

   // storage and arithmetic
   zsn_dp #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
      .clock, .reset, .req_sample, .cmd, .stat, .rsp_normalised, .rsp_degenerate
   );

   // no sample is stored while responses are pending
   `ASSERT_IMPLIES(a_no_load_busy, clock, reset, rsp_valid, !cmd.load, "load while responding")
   // a stalled response stays up
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "response dropped")
   // divider and root never run together
   `ASSERT_IMPLIES(a_one_unit, clock, reset, stat.sqrt_busy, !stat.div_busy, "units overlap")
endmodule

[src/zsn_ctrl.sv]
module zsn_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last_in,
   output logic                 req_stall,
   output logic                 rsp_valid,
   output logic                 rsp_last_out,
   input  logic                 rsp_stall,
   output zsn_pkg::zsn_cmd_type cmd,
   input  zsn_pkg::zsn_stat_type stat
);
   typedef enum logic [3:0] {
      S_LOAD, S_MEAN, S_MEAN_W, S_VAR_RD, S_VAR_ACC, S_VAR_SUM, S_VAR_DIV, S_VAR_W,
      S_SQRT_W, S_Z_RD, S_Z_DIV, S_Z_W, S_OUT, S_CLEAR
   } state_type;

   state_type  state_ff, state_in;
   logic [6:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       last_ff, last_in_w;
   logic       req_acc;

   assign req_stall = (state_ff != S_LOAD);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_last_out = last_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      last_in_w    = last_ff;
      cmd          = '0;
      cmd.rd_addr  = idx_ff;
      unique case (state_ff)
         S_LOAD: begin
            cmd.load = req_acc && !stat.full;
            cmd.drop = req_acc && stat.full;
            if (req_acc && req_last_in) begin
               state_in = S_MEAN;
            end
         end
         S_MEAN: begin
            cmd.mean_start = 1'b1;
            cmd.var_clr    = 1'b1;
            idx_in         = '0;
            state_in       = S_MEAN_W;
         end
         S_MEAN_W: begin
            if (!stat.div_busy) begin
               state_in = S_VAR_RD;
            end
         end
         S_VAR_RD: begin
            cmd.rd_en = 1'b1;
            idx_in    = idx_ff + 7'd1;
            state_in  = S_VAR_ACC;
         end
         S_VAR_ACC: begin
            cmd.var_acc = 1'b1;
            if (idx_ff == stat.count) begin
               state_in = S_VAR_SUM;
            end else begin
               state_in = S_VAR_RD;
            end
         end
         // last square lands in the sum
         S_VAR_SUM: begin
            state_in = S_VAR_DIV;
         end
         S_VAR_DIV: begin
            cmd.var_start = 1'b1;
            state_in      = S_VAR_W;
         end
         S_VAR_W: begin
            if (!stat.div_busy) begin
               cmd.sqrt_start = 1'b1;
               state_in       = S_SQRT_W;
            end
         end
         S_SQRT_W: begin
            if (!stat.sqrt_busy) begin
               idx_in   = '0;
               state_in = S_Z_RD;
            end
         end
         S_Z_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_Z_DIV;
         end
         S_Z_DIV: begin
            cmd.z_start = 1'b1;
            state_in    = S_Z_W;
         end
         S_Z_W: begin
            if (!stat.div_busy) begin
               rsp_valid_in = 1'b1;
               last_in_w    = (idx_ff + 7'd1 == stat.count);
               state_in     = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               idx_in       = idx_ff + 7'd1;
               if (last_ff) begin
                  state_in = S_CLEAR;
               end else begin
                  state_in = S_Z_RD;
               end
            end
         end
         S_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = S_LOAD;
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in_w;
      end
   end
endmodule

[src/zsn_dp.sv]
module zsn_dp #(
   parameter int MAX_SAMPLES = zsn_pkg::MAX_SAMPLES_DEF,
   parameter int SAMPLE_BITS = zsn_pkg::SAMPLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic signed [15:0]    req_sample,
   input  zsn_pkg::zsn_cmd_type  cmd,
   output zsn_pkg::zsn_stat_type stat,
   output logic signed [15:0]    rsp_normalised,
   output logic                  rsp_degenerate
);
   localparam int AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int XB  = (SAMPLE_BITS <= 16) ? SAMPLE_BITS : 17;
   localparam int SB  = XB + 7;        // sum width
   localparam int DB  = XB + 10;       // deviation in Q.8 with margin
   localparam int QB  = 2 * DB + 7;    // sum of squares
   localparam int NB  = QB;            // divider width
   localparam int RB  = (QB + 1) / 2;  // root width
   localparam int CW  = $clog2(NB + 1);

   logic signed [XB-1:0] mem_ff [MAX_SAMPLES];
   logic signed [XB-1:0] rd_ff;
   logic [6:0]           count_ff;
   logic signed [SB-1:0] sum_ff;
   logic                 ovf_ff;
   logic signed [DB-1:0] mean_ff;
   logic [QB-1:0]        sq_ff;
   logic [RB-1:0]        sd_ff;
   logic signed [15:0]   z_ff;
   logic signed [XB-1:0] x_w;
   logic [15:0]          raw_w;

   // sample taking: sign extend or zero extend the low bits
   always_comb begin
      raw_w = req_sample;
      if (SAMPLE_BITS <= 16) begin
         x_w = XB'(signed'(raw_w[XB-1:0]));
      end else begin
         x_w = XB'({1'b0, raw_w});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mem_ff[count_ff[AW-1:0]] <= x_w;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem_ff[cmd.rd_addr[AW-1:0]];
      end
   end

   assign stat.full  = (count_ff == 7'(MAX_SAMPLES));
   assign stat.count = count_ff;

   // deviation of the read entry
   logic signed [DB-1:0] dev_w;
   logic [DB-1:0]        dmag_w;
   assign dev_w  = (DB'(rd_ff) <<< 8) - mean_ff;
   assign dmag_w = dev_w[DB-1] ? DB'(-dev_w) : DB'(dev_w);

   logic [2*DB-1:0] sqr_ff;
   logic            acc_d_ff;

   // shared restoring divider: quotient of num by den, one bit a cycle
   logic [NB-1:0] dnum_ff, dden_ff, drem_ff, dquo_ff;
   logic [CW-1:0] dcnt_ff;
   logic          dbusy_ff;
   logic [1:0]    dmode_ff; // 0 mean, 1 variance, 2 z
   logic          dneg_ff;
   logic [NB:0]   dtry_w;
   assign dtry_w = {drem_ff, dnum_ff[NB-1]} - {1'b0, dden_ff};
   assign stat.div_busy = dbusy_ff;

   // square root, two bits a cycle over an even-width frame
   logic [2*RB-1:0] sv_ff;
   logic [RB-1:0] sr_ff;
   logic [RB+1:0] srem_ff;
   logic [$clog2(RB+1)-1:0] scnt_ff;
   logic sbusy_ff;
   logic [RB+1:0] stry_w;
   logic [RB+1:0] srem_sh_w;
   assign srem_sh_w = {srem_ff[RB-1:0], sv_ff[2*RB-1:2*RB-2]};
   assign stry_w    = srem_sh_w - {sr_ff, 2'b01};
   assign stat.sqrt_busy = sbusy_ff;

   logic [NB-1:0] mabs_w;
   logic [NB-1:0] zq_w;
   logic signed [NB:0] zs_w;
   assign mabs_w = sum_ff[SB-1] ? NB'(-sum_ff) : NB'(sum_ff);

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         count_ff <= '0;
         sum_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         if (cmd.load) begin
            count_ff <= count_ff + 7'd1;
            sum_ff   <= sum_ff + SB'(x_w);
         end
         // a request arriving while full is dropped
         if (cmd.drop) begin
            ovf_ff <= 1'b1;
         end
      end
      if (reset) begin
         dbusy_ff <= 1'b0;
         sbusy_ff <= 1'b0;
         acc_d_ff <= 1'b0;
      end else begin
         acc_d_ff <= cmd.var_acc;
         if (cmd.mean_start) begin
            // (|sum|*256 + n/2) / n
            dnum_ff  <= (mabs_w << 8) + NB'(count_ff >> 1);
            dden_ff  <= NB'(count_ff);
            dneg_ff  <= sum_ff[SB-1];
            dmode_ff <= 2'd0;
            drem_ff  <= '0;
            dcnt_ff  <= CW'(NB);
            dbusy_ff <= 1'b1;
         end else if (cmd.var_start) begin
            dnum_ff  <= sq_ff;
            dden_ff  <= NB'(count_ff);
            dneg_ff  <= 1'b0;
            dmode_ff <= 2'd1;
            drem_ff  <= '0;
            dcnt_ff  <= CW'(NB);
            dbusy_ff <= 1'b1;
         end else if (cmd.z_start) begin
            // (|d|*2048 + sd/2) / sd, skipped when sd is zero
            dnum_ff  <= (NB'(dmag_w) << 11) + NB'(sd_ff >> 1);
            dden_ff  <= NB'(sd_ff);
            dneg_ff  <= dev_w[DB-1];
            dmode_ff <= 2'd2;
            drem_ff  <= '0;
            dcnt_ff  <= CW'(NB);
            dbusy_ff <= (sd_ff != '0);
         end else if (dbusy_ff) begin
            if (!dtry_w[NB]) begin
               drem_ff <= dtry_w[NB-1:0];
               dquo_ff <= {dquo_ff[NB-2:0], 1'b1};
            end else begin
               drem_ff <= {drem_ff[NB-2:0], dnum_ff[NB-1]};
               dquo_ff <= {dquo_ff[NB-2:0], 1'b0};
            end
            dnum_ff <= dnum_ff << 1;
            dcnt_ff <= dcnt_ff - CW'(1);
            if (dcnt_ff == CW'(1)) begin
               dbusy_ff <= 1'b0;
            end
         end
         if (cmd.sqrt_start) begin
            sv_ff    <= (2*RB)'(dquo_ff[QB-1:0]);
            sr_ff    <= '0;
            srem_ff  <= '0;
            scnt_ff  <= ($clog2(RB+1))'(RB);
            sbusy_ff <= 1'b1;
         end else if (sbusy_ff) begin
            if (!stry_w[RB+1]) begin
               srem_ff <= stry_w;
               sr_ff   <= {sr_ff[RB-2:0], 1'b1};
            end else begin
               srem_ff <= srem_sh_w;
               sr_ff   <= {sr_ff[RB-2:0], 1'b0};
            end
            sv_ff   <= sv_ff << 2;
            scnt_ff <= scnt_ff - 1'b1;
            if (scnt_ff == 1) begin
               sbusy_ff <= 1'b0;
            end
         end
      end
   end

   // finished divider results
   logic div_done_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         div_done_ff <= 1'b0;
      end else begin
         div_done_ff <= dbusy_ff && (dcnt_ff == CW'(1));
      end
      if (div_done_ff) begin
         unique case (dmode_ff)
            2'd0:    mean_ff <= dneg_ff ? -DB'(dquo_ff) : DB'(dquo_ff);
            2'd1:    ;
            default: z_ff <= zs_w > 17'sd32767 ? 16'sd32767 :
                             (zs_w < -17'sd32768 ? -16'sd32768 : 16'(zs_w));
         endcase
      end
      // zero deviation: output is zero without a division
      if (cmd.z_start && sd_ff == '0) begin
         z_ff <= '0;
      end
      if (cmd.var_clr) begin
         sq_ff <= '0;
      end else if (acc_d_ff) begin
         sq_ff <= sq_ff + QB'(sqr_ff);
      end
      if (cmd.var_acc) begin
         sqr_ff <= dmag_w * dmag_w;
      end
      if (sbusy_ff && scnt_ff == 1) begin
         sd_ff <= {sr_ff[RB-2:0], !stry_w[RB+1]};
      end
   end

   assign zq_w = dquo_ff;
   assign zs_w = (|zq_w[NB-1:16]) ? (dneg_ff ? -(NB+1)'(32768) : (NB+1)'(32767))
                 : (dneg_ff ? -(NB+1)'(zq_w) : (NB+1)'(zq_w));

   assign rsp_normalised = z_ff;
   assign rsp_degenerate = (sd_ff == '0) || ovf_ff;
endmodule
